[rtl/core/lsh_pkg.sv]
// Shared constants and types of the 3x3 Laplacian sharpening filter.
`default_nettype none

package lsh_pkg;

    localparam int LSH_MAX_ROW_SAMPLES = 4096;
    localparam int LSH_ADDR_W          = $clog2(LSH_MAX_ROW_SAMPLES);
    localparam int LSH_SAMPLE_W        = 8;
    localparam int LSH_WIDTH_W         = 11;
    localparam int LSH_HEIGHT_W        = 13;
    localparam int LSH_CHAN_W          = 3;
    localparam int LSH_CFG_DATA_W      = 13;
    localparam int LSH_CFG_INDEX_W     = 2;

    // Register indexes of the configuration port.
    localparam logic [LSH_CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [LSH_CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [LSH_CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Input operation codes carried on s_tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic                    en;
        logic [LSH_ADDR_W-1:0]   addr;
        logic [LSH_SAMPLE_W-1:0] older_data;
        logic [LSH_SAMPLE_W-1:0] prior_data;
    } lsh_wr_t;

    typedef struct packed {
        logic [LSH_ADDR_W-1:0] older_addr;
        logic [LSH_ADDR_W-1:0] prior_addr;
    } lsh_rd_t;

endpackage

`default_nettype wire

[rtl/core/lsh_line_buf.sv]
// Two line buffers: the row two back and the row one back, one read port each.
`default_nettype none

module lsh_line_buf
    import lsh_pkg::*;
(
    input  wire logic                    aclk,
    input  wire lsh_wr_t                 wr,
    input  wire lsh_rd_t                 rd,
    output logic [LSH_SAMPLE_W-1:0]      older_q,
    output logic [LSH_SAMPLE_W-1:0]      prior_q
);

    logic [LSH_SAMPLE_W-1:0] older_mem [0:LSH_MAX_ROW_SAMPLES-1];
    logic [LSH_SAMPLE_W-1:0] prior_mem [0:LSH_MAX_ROW_SAMPLES-1];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            older_mem[wr.addr] <= wr.older_data;
            prior_mem[wr.addr] <= wr.prior_data;
        end
        older_q <= older_mem[rd.older_addr];
        prior_q <= prior_mem[rd.prior_addr];
    end

endmodule

`default_nettype wire

[rtl/core/laplacian_sharpen_3x3_top.sv]
// Top level of the 3x3 Laplacian sharpening filter with its sequencing and output stage.
//
// Input channel s_*: one channel sample per transaction in raster order, channels
// interleaved; s_tuser selects a pixel sample or a drain tick. Each pixel sample of
// row r (r >= 1) yields the sharpened sample of row r-1 at the same position; row 0
// yields nothing. After the last row, one drain tick per sample yields the zero
// bottom row, the last one flagged on m_tuser. m_tlast marks the end of each row.
// Border rows and border pixel columns are zero.
// Throughput is one transaction per cycle while s_tready is high. Each result is registered
// into the output register, or into a skid register that takes one more result while the
// receiver stalls; s_tready also drops while that skid register is full.
// The line buffers are read one sample ahead of the stream, so after reset and after
// each register write s_tready stays low while the first read completes. Reset clears
// positions and restores 640 x 480 with one channel; the line buffer contents are not
// cleared. A write to one of the three registers restarts the frame.
`default_nettype none

module laplacian_sharpen_3x3_top
    import lsh_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [LSH_SAMPLE_W-1:0]    s_tdata,   // [7:0] sample
    input  wire logic                       s_tuser,   // [0] operation
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [LSH_SAMPLE_W-1:0]         m_tdata,   // [7:0] result_sample
    output logic                            m_tlast,   // end_of_row
    output logic                            m_tuser,   // [0] end_of_frame
    input  wire logic                       cfg_we,
    input  wire logic [LSH_CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LSH_CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int ROW_LEN_W = LSH_ADDR_W + 1;

    logic [LSH_WIDTH_W-1:0]  width_raw_reg;
    logic [LSH_HEIGHT_W-1:0] height_raw_reg;
    logic [LSH_CHAN_W-1:0]   chans_raw_reg;
    logic [LSH_WIDTH_W-1:0]  width_c;
    logic [LSH_HEIGHT_W-1:0] height_c;
    logic [LSH_CHAN_W-1:0]   chans_c;
    logic [ROW_LEN_W-1:0]    row_len;
    logic                    cfg_hit;

    logic [LSH_ADDR_W-1:0]   sample_reg, sample_next;
    logic [LSH_ADDR_W-1:0]   row_reg, row_next;
    logic [LSH_ADDR_W-1:0]   drain_reg, drain_next;
    logic [1:0]              chan_reg, chan_next;
    logic [9:0]              pcol_reg, pcol_next;
    logic                    await_reg, await_next;
    logic                    hold_reg;

    logic [ROW_LEN_W-1:0]    sample_inc, row_inc, drain_inc, prior_sum;
    logic [LSH_CHAN_W-1:0]   chan_inc;
    logic                    row_end, chan_end, frame_end, drain_end;
    logic                    accept, pix_go, drain_go, produce;

    lsh_wr_t                 wr;
    lsh_rd_t                 rd;
    logic [LSH_SAMPLE_W-1:0] older_q, prior_q;
    logic [LSH_SAMPLE_W-1:0] tap_reg [1:8];
    logic [LSH_SAMPLE_W-1:0] center, left;
    logic                    interior;
    logic signed [11:0]      acc;
    logic [LSH_SAMPLE_W-1:0] sharp;
    logic [LSH_SAMPLE_W-1:0] res_data;
    logic                    res_last, res_user;

    logic                    out_valid_reg, skid_valid_reg;
    logic [LSH_SAMPLE_W-1:0] out_data_reg, skid_data_reg;
    logic                    out_last_reg, skid_last_reg;
    logic                    out_user_reg, skid_user_reg;

    // Effective configuration after clamping to the supported ranges.
    always_comb begin
        if (width_raw_reg < 11'd3)         width_c = 11'd3;
        else if (width_raw_reg > 11'd1024) width_c = 11'd1024;
        else                               width_c = width_raw_reg;
        if (height_raw_reg < 13'd3)          height_c = 13'd3;
        else if (height_raw_reg > 13'd4096)  height_c = 13'd4096;
        else                                 height_c = height_raw_reg;
        if (chans_raw_reg == 3'd0)     chans_c = 3'd1;
        else if (chans_raw_reg > 3'd4) chans_c = 3'd4;
        else                           chans_c = chans_raw_reg;
        row_len = ROW_LEN_W'(width_c) * ROW_LEN_W'(chans_c);
    end

    assign cfg_hit = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT
                                || cfg_index == CFG_CHANNEL_COUNT);

    assign s_tready = !hold_reg && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pix_go   = accept && (s_tuser == OP_PIXEL) && !await_reg;
    assign drain_go = accept && (s_tuser == OP_DRAIN) && await_reg;
    assign produce  = (pix_go && row_reg != '0) || drain_go;

    assign sample_inc = {1'b0, sample_reg} + 13'd1;
    assign row_inc    = {1'b0, row_reg} + 13'd1;
    assign drain_inc  = {1'b0, drain_reg} + 13'd1;
    assign chan_inc   = {1'b0, chan_reg} + 3'd1;
    assign row_end    = sample_inc == row_len;
    assign chan_end   = chan_inc == chans_c;
    assign frame_end  = row_end && (row_inc >= height_c);
    assign drain_end  = drain_inc >= row_len;

    always_comb begin
        sample_next = sample_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        chan_next   = chan_reg;
        pcol_next   = pcol_reg;
        await_next  = await_reg;
        if (cfg_hit) begin
            sample_next = '0;
            row_next    = '0;
            drain_next  = '0;
            chan_next   = '0;
            pcol_next   = '0;
            await_next  = 1'b0;
        end else if (pix_go) begin
            if (row_end) begin
                sample_next = '0;
                chan_next   = '0;
                pcol_next   = '0;
                if (frame_end) begin
                    row_next   = '0;
                    drain_next = '0;
                    await_next = 1'b1;
                end else begin
                    row_next = row_inc[LSH_ADDR_W-1:0];
                end
            end else begin
                sample_next = sample_inc[LSH_ADDR_W-1:0];
                if (chan_end) begin
                    chan_next = '0;
                    pcol_next = pcol_reg + 10'd1;
                end else begin
                    chan_next = chan_inc[1:0];
                end
            end
        end else if (drain_go) begin
            if (drain_end) begin
                drain_next = '0;
                await_next = 1'b0;
            end else begin
                drain_next = drain_inc[LSH_ADDR_W-1:0];
            end
        end
    end

    // Fetch for the next sample position: the row two back at that position and the
    // row one back one pixel to the right, wrapped into the start of the row.
    always_comb begin
        prior_sum = {1'b0, sample_next} + ROW_LEN_W'(chans_c);
        if (prior_sum >= row_len) prior_sum = prior_sum - row_len;
        rd.older_addr = sample_next;
        rd.prior_addr = prior_sum[LSH_ADDR_W-1:0];
    end

    // The previous row's samples pass through a short tap line, so the center and the
    // left neighbor are taken from earlier fetches.
    always_comb begin
        case (chans_c)
            3'd1: begin
                center = tap_reg[1];
                left   = tap_reg[2];
            end
            3'd2: begin
                center = tap_reg[2];
                left   = tap_reg[4];
            end
            3'd3: begin
                center = tap_reg[3];
                left   = tap_reg[6];
            end
            default: begin
                center = tap_reg[4];
                left   = tap_reg[8];
            end
        endcase
    end

    assign wr.en         = pix_go;
    assign wr.addr       = sample_reg;
    assign wr.older_data = center;
    assign wr.prior_data = s_tdata;

    lsh_line_buf u_line_buf (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .older_q (older_q),
        .prior_q (prior_q)
    );

    assign interior = (row_reg >= 12'd2) && (pcol_reg != 10'd0)
                      && ({1'b0, pcol_reg} != (width_c - 11'd1));

    always_comb begin
        acc = $signed(12'({center, 2'b00}) + 12'(center))
              - $signed(12'(left) + 12'(prior_q) + 12'(older_q) + 12'(s_tdata));
        if (acc < 12'sd0)        sharp = 8'd0;
        else if (acc > 12'sd255) sharp = 8'd255;
        else                     sharp = acc[7:0];
        if (drain_go) begin
            res_data = '0;
            res_last = drain_end;
            res_user = drain_end;
        end else begin
            res_data = interior ? sharp : '0;
            res_last = row_end;
            res_user = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= 11'd640;
            height_raw_reg <= 13'd480;
            chans_raw_reg  <= 3'd1;
            hold_reg       <= 1'b1;
            sample_reg     <= '0;
            row_reg        <= '0;
            drain_reg      <= '0;
            chan_reg       <= '0;
            pcol_reg       <= '0;
            await_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:   width_raw_reg  <= cfg_wdata[LSH_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT:  height_raw_reg <= cfg_wdata[LSH_HEIGHT_W-1:0];
                    CFG_CHANNEL_COUNT: chans_raw_reg  <= cfg_wdata[LSH_CHAN_W-1:0];
                    default: ;
                endcase
            end
            hold_reg   <= cfg_hit;
            sample_reg <= sample_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
            chan_reg   <= chan_next;
            pcol_reg   <= pcol_next;
            await_reg  <= await_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_go) begin
            tap_reg[1] <= prior_q;
            for (int k = 2; k <= 8; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (produce) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_valid_reg && m_tready) begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res_data;
                out_last_reg <= res_last;
                out_user_reg <= res_user;
            end else begin
                skid_data_reg <= res_data;
                skid_last_reg <= res_last;
                skid_user_reg <= res_user;
            end
        end else if (out_valid_reg && m_tready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
            out_user_reg <= skid_user_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // The skid entry is only ever filled behind a waiting output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // The prefetch must settle after a configuration write before a sample is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> !s_tready)
        else $error("input accepted before the line buffer fetch settled");

    // Positions stay inside the configured row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, sample_reg} < row_len) && ({1'b0, pcol_reg} < width_c)
        && ({1'b0, chan_reg} < chans_c))
        else $error("sample position outside the row");

    // While the bottom row drains, no row is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> (sample_reg == '0 && row_reg == '0 && ({1'b0, drain_reg} < row_len)))
        else $error("drain in progress with a row still open");

    // A drain result marks the end of the frame exactly at the end of its row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of frame without end of row");

endmodule

`default_nettype wire

[verif/tb_laplacian_sharpen_3x3_top.sv]
// Testbench of the 3x3 Laplacian sharpening filter: random and directed frames checked against a predictor.
`default_nettype none

module tb_laplacian_sharpen_3x3_top;
    import lsh_pkg::*;

    // The one index of the configuration port that selects no register.
    localparam logic [LSH_CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int RANDOM_ITEM_TARGET = 950;

    typedef struct packed {
        logic [LSH_SAMPLE_W-1:0] pixel;
        logic                    row_end;
        logic                    frame_end;
    } sharpened_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [LSH_SAMPLE_W-1:0]    s_tdata   = '0;
    logic                       s_tuser   = OP_PIXEL;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [LSH_SAMPLE_W-1:0]    m_tdata;
    logic                       m_tlast;
    logic                       m_tuser;
    logic                       cfg_we    = 1'b0;
    logic [LSH_CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [LSH_CFG_DATA_W-1:0]  cfg_wdata = '0;

    laplacian_sharpen_3x3_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state: registers, effective geometry, stream position and line buffers.
    bit [LSH_WIDTH_W-1:0]    width_reg;
    bit [LSH_HEIGHT_W-1:0]   height_reg;
    bit [LSH_CHAN_W-1:0]     chans_reg;
    int unsigned             eff_width, eff_height, eff_chans, eff_row_len;
    int unsigned             row_pos, sample_pos, drain_pos;
    bit                      awaiting_drain;
    bit [LSH_SAMPLE_W-1:0]   older_line [LSH_MAX_ROW_SAMPLES];
    bit [LSH_SAMPLE_W-1:0]   prior_line [LSH_MAX_ROW_SAMPLES];

    sharpened_t expected_sharpened [$];
    sharpened_t next_sharpened;
    sharpened_t oldest_sharpened;

    bit in_fire;
    int mismatch_count = 0;
    int rx_stall_left  = 0;
    bit rx_stalls_on   = 1'b0;
    bit tx_gaps_on     = 1'b0;
    int random_items   = 0;

    function automatic void restart_frame();
        row_pos        = 0;
        sample_pos     = 0;
        drain_pos      = 0;
        awaiting_drain = 1'b0;
    endfunction

    function automatic void update_geometry();
        eff_width   = (width_reg < 3) ? 3 : (width_reg > 1024) ? 1024 : width_reg;
        eff_height  = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
        eff_chans   = (chans_reg < 1) ? 1 : (chans_reg > 4) ? 4 : chans_reg;
        eff_row_len = eff_width * eff_chans;
        if (eff_row_len > LSH_MAX_ROW_SAMPLES) begin
            eff_row_len = LSH_MAX_ROW_SAMPLES;
        end
    endfunction

    function automatic void apply_register(input logic [LSH_CFG_INDEX_W-1:0] index,
                                           input logic [LSH_CFG_DATA_W-1:0] data);
        case (index)
            CFG_IMAGE_WIDTH: begin
                width_reg = data[LSH_WIDTH_W-1:0];
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = data[LSH_HEIGHT_W-1:0];
            end
            CFG_CHANNEL_COUNT: begin
                chans_reg = data[LSH_CHAN_W-1:0];
            end
            default: begin
                return;
            end
        endcase
        update_geometry();
        restart_frame();
    endfunction

    // Advances the predictor by one input transaction; returns 1 when it yields a result.
    function automatic bit predict_sharpen(input logic op, input logic [LSH_SAMPLE_W-1:0] smp,
                                           output sharpened_t res);
        int          acc;
        int unsigned s;
        int unsigned pcol;
        bit          produced;
        res      = '0;
        produced = 1'b0;
        if (op == OP_DRAIN) begin
            if (!awaiting_drain) begin
                return 1'b0;
            end
            res.row_end   = (drain_pos + 1 >= eff_row_len);
            res.frame_end = res.row_end;
            drain_pos++;
            if (drain_pos >= eff_row_len) begin
                restart_frame();
            end
            return 1'b1;
        end
        if (awaiting_drain) begin
            return 1'b0;
        end
        s = sample_pos;
        if (row_pos >= 1) begin
            pcol = s / eff_chans;
            acc  = 0;
            if (row_pos >= 2 && pcol != 0 && pcol != eff_width - 1) begin
                // The left neighbor of the row above has already moved to the older line.
                acc = 5 * int'(prior_line[s]) - int'(older_line[s - eff_chans])
                    - int'(prior_line[s + eff_chans]) - int'(older_line[s]) - int'(smp);
                if (acc < 0) begin
                    acc = 0;
                end
                if (acc > 255) begin
                    acc = 255;
                end
            end
            res.pixel   = acc[LSH_SAMPLE_W-1:0];
            res.row_end = (s + 1 >= eff_row_len);
            produced    = 1'b1;
        end
        older_line[s] = prior_line[s];
        prior_line[s] = smp;
        sample_pos++;
        if (sample_pos >= eff_row_len) begin
            sample_pos = 0;
            row_pos++;
            if (row_pos >= eff_height) begin
                row_pos        = 0;
                drain_pos      = 0;
                awaiting_drain = 1'b1;
            end
        end
        return produced;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Predicts accepted input transactions and checks accepted result transactions.
    always @(posedge aclk) begin
        in_fire = 1'b0;
        if (!aresetn) begin
            width_reg  = 640;
            height_reg = 480;
            chans_reg  = 1;
            update_geometry();
            restart_frame();
        end else begin
            if (cfg_we) begin
                apply_register(cfg_index, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                in_fire = 1'b1;
                if (predict_sharpen(s_tuser, s_tdata, next_sharpened)) begin
                    expected_sharpened.push_back(next_sharpened);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_sharpened.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transaction, data %0d", m_tdata));
                end else begin
                    oldest_sharpened = expected_sharpened.pop_front();
                    if (m_tdata !== oldest_sharpened.pixel) begin
                        report_mismatch($sformatf("result_sample %0d, expected %0d",
                                                  m_tdata, oldest_sharpened.pixel));
                    end
                    if (m_tlast !== oldest_sharpened.row_end) begin
                        report_mismatch($sformatf("end_of_row %b, expected %b",
                                                  m_tlast, oldest_sharpened.row_end));
                    end
                    if (m_tuser !== oldest_sharpened.frame_end) begin
                        report_mismatch($sformatf("end_of_frame %b, expected %b",
                                                  m_tuser, oldest_sharpened.frame_end));
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LSH_SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return 8'h00;
        end
        if (r < 4) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver back-pressure.
    always @(negedge aclk) begin
        if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (rx_stalls_on) begin
                rx_stall_left = pick_gap();
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic op, input logic [LSH_SAMPLE_W-1:0] smp);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= op;
        do @(negedge aclk); while (!in_fire);
    endtask

    task automatic send_pixels(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            send_item(OP_PIXEL, rand_sample());
        end
    endtask

    task automatic send_drains(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++) begin
            send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
        end
    endtask

    // Waits until every result has arrived and the pipeline has emptied.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_sharpened.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [LSH_CFG_INDEX_W-1:0] index,
                             input logic [LSH_CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [LSH_CFG_DATA_W-1:0] w, input logic [LSH_CFG_DATA_W-1:0] h,
                             input logic [LSH_CFG_DATA_W-1:0] c);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, c);
    endtask

    // The reset geometry of 640 pixels per row: one full row and part of the next.
    task automatic test_reset_geometry();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_pixels(eff_row_len + 40);
        random_items += eff_row_len + 40;
        settle();
    endtask

    // A single bright and a single dark center pixel, with both kinds of ignored transaction.
    task automatic test_directed_frames();
        int i;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        configure(3, 3, 1);
        for (i = 0; i < 9; i++) begin
            if (i == 4) begin
                send_item(OP_DRAIN, 8'hA5);
            end
            send_item(OP_PIXEL, (i == 4) ? 8'hFF : 8'h00);
        end
        send_item(OP_PIXEL, 8'h5A);
        send_drains(3);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        for (i = 0; i < 9; i++) begin
            send_item(OP_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
        end
        send_drains(3);
    endtask

    task automatic test_register_limits();
        int unsigned n;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        configure(0, 0, 0);
        send_pixels(eff_row_len * eff_height);
        send_drains(eff_row_len);

        // A write to the unused index must leave the frame in progress alone.
        configure(2, 2, 7);
        n = eff_row_len * eff_height;
        send_pixels(n / 2);
        settle();
        write_reg(CFG_UNUSED_INDEX, 13'($urandom));
        send_pixels(n - n / 2);
        send_drains(eff_row_len);

        // A register write part way through a frame starts a new one.
        configure(5, 4, 3);
        send_pixels(eff_row_len + 7);
        settle();
        write_reg(CFG_CHANNEL_COUNT, 13'd2);
        send_pixels(eff_row_len * eff_height);
        send_drains(eff_row_len);

        // Largest geometry, reached by clamping all-ones values: the start of the first row.
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        configure(13'h1FFF, 13'h1FFF, 13'h1FFF);
        send_pixels(16);
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned          frame_len;
        int unsigned          n;
        int unsigned          i;
        bit                   need_config;
        logic [LSH_CFG_DATA_W-1:0] w, h, c;
        need_config = 1'b1;
        while (random_items < RANDOM_ITEM_TARGET) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if (need_config || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       w = 13'($urandom_range(0, 2));
                    1:       w = 13'($urandom_range(9, 40));
                    default: w = 13'($urandom_range(3, 8));
                endcase
                // Bits above the register width are dropped.
                w[12:11] = 2'($urandom_range(0, 3));
                h = 13'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 5));
                c = 13'(($urandom_range(0, 4) == 0) ? ($urandom_range(5, 8) % 8)
                                                    : $urandom_range(1, 4));
                configure(w, h, c);
            end
            frame_len = eff_row_len * eff_height;
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, frame_len - 1);
            end else begin
                n = frame_len;
            end
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
                end
                send_item(OP_PIXEL, rand_sample());
            end
            random_items += n;
            if (n < frame_len) begin
                need_config = 1'b1;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(OP_PIXEL, rand_sample());
                end
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, eff_row_len - 1);
                    need_config = 1'b1;
                end else begin
                    n = eff_row_len;
                    need_config = 1'b0;
                end
                send_drains(n);
                random_items += n;
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_geometry();
        test_directed_frames();
        test_register_limits();
        test_random_frames();
        settle();
        repeat (16) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("laplacian_sharpen_3x3_top test passed");
        end else begin
            $display("laplacian_sharpen_3x3_top test failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("laplacian_sharpen_3x3_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
